[rtl/klt_pkg.sv]
// shared types and constants of the keyed lock table
package klt_pkg;

  // table geometry
  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int AC_W       = $clog2(TABLE_SIZE + 1);
  localparam int POS_W      = 16;
  localparam int CNT_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WAKE_ONE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input transfer
    logic cmp;     // run the key compare across all slots
    logic commit;  // update the table and load the result register
  } klt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } klt_sts_t;

endpackage

[rtl/klt_ctrl.sv]
// controller state machine of the keyed lock table
module klt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  klt_pkg::klt_sts_t sts,
  output klt_pkg::klt_cmd_t cmd
);
  import klt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   commit;

  // commit once the result register has room
  assign commit   = (state_r == S_UPD) && sts.out_free;
  assign in_ready = (state_r == S_IDLE) || commit;

  assign cmd.load   = in_valid && in_ready;
  assign cmd.cmp    = (state_r == S_CMP);
  assign cmd.commit = commit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (commit) state_nxt = in_valid ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // a transfer is taken only when idle or at a commit
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE || commit))
    else $error("input transfer taken while busy");

  // every compare is followed by an update cycle
  a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp |=> (state_r == S_UPD))
    else $error("compare not followed by update");

  // a load always leads into the compare cycle
  a_load_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.cmp)
    else $error("load not followed by compare");
`endif

endmodule

[rtl/klt_dp.sv]
// datapath of the keyed lock table: slots, free stack and result register
module klt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  klt_pkg::klt_cmd_t                cmd,
  output klt_pkg::klt_sts_t                sts,
  input  logic                             in_mode,
  input  logic [klt_pkg::POS_W-1:0]        in_pos_i,
  input  logic [klt_pkg::POS_W-1:0]        in_pos_k,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [klt_pkg::STATUS_W-1:0]     out_status,
  output logic [klt_pkg::OUT_SLOT_W-1:0]   out_slot
);
  import klt_pkg::*;

  // captured request
  logic             mode_r;
  logic [POS_W-1:0] pos_i_r;
  logic [POS_W-1:0] pos_k_r;

  // slot table
  logic [POS_W-1:0]  key_first_r  [TABLE_SIZE];
  logic [POS_W-1:0]  key_second_r [TABLE_SIZE];
  logic [CNT_W-1:0]  cnt_r        [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] act_r, act_nxt;

  // free slots, top of stack at index active_count
  logic [SLOT_W-1:0] stk_r [TABLE_SIZE];
  logic [AC_W-1:0]   ac_r, ac_nxt;

  // compare results
  logic [TABLE_SIZE-1:0] match;
  logic [SLOT_W-1:0]     match_slot;
  logic                  hit_r;
  logic [SLOT_W-1:0]     hit_slot_r;

  // result register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;

  // update decisions
  logic [CNT_W-1:0]  hit_cnt;
  logic              full;
  logic [SLOT_W-1:0] top_slot;
  logic [AC_W-1:0]   ac_dec;
  logic              wr_key;
  logic              wr_cnt;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  wr_cnt_val;
  logic              push;

  assign sts.out_free = !out_valid_r || out_ready;

  // parallel key compare over active slots
  always_comb begin
    match_slot = '0;
    for (int s = 0; s < TABLE_SIZE; s++) begin
      match[s] = act_r[s] && (key_first_r[s] == pos_i_r) && (key_second_r[s] == pos_k_r);
      if (match[s]) match_slot = SLOT_W'(s);
    end
  end

  assign hit_cnt  = cnt_r[hit_slot_r];
  assign full     = (ac_r >= AC_W'(TABLE_SIZE));
  assign top_slot = stk_r[ac_r[SLOT_W-1:0]];
  assign ac_dec   = ac_r - AC_W'(1);

  // table update and result
  always_comb begin
    status_nxt = ST_NOT_FOUND;
    slot_nxt   = '0;
    act_nxt    = act_r;
    ac_nxt     = ac_r;
    wr_key     = 1'b0;
    wr_cnt     = 1'b0;
    wr_slot    = hit_slot_r;
    wr_cnt_val = hit_cnt;
    push       = 1'b0;
    if (mode_r == MODE_LOCK) begin
      if (hit_r) begin
        slot_nxt = hit_slot_r;
        if (hit_cnt >= COUNT_MAX) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          status_nxt = ST_WAIT;
          wr_cnt     = 1'b1;
          wr_cnt_val = hit_cnt + CNT_W'(1);
        end
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt       = ST_GRANTED;
        slot_nxt         = top_slot;
        wr_slot          = top_slot;
        wr_key           = 1'b1;
        wr_cnt           = 1'b1;
        wr_cnt_val       = CNT_W'(1);
        act_nxt[top_slot] = 1'b1;
        ac_nxt           = ac_r + AC_W'(1);
      end
    end else begin
      if (hit_r) begin
        slot_nxt = hit_slot_r;
        wr_cnt   = 1'b1;
        if (hit_cnt > CNT_W'(1)) begin
          status_nxt = ST_WAKE_ONE;
          wr_cnt_val = hit_cnt - CNT_W'(1);
        end else begin
          status_nxt          = ST_FREED;
          wr_cnt_val          = '0;
          act_nxt[hit_slot_r] = 1'b0;
          ac_nxt              = ac_dec;
          push                = 1'b1;
        end
      end
    end
  end

  // request capture and compare stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      pos_i_r <= in_pos_i;
      pos_k_r <= in_pos_k;
    end
    if (cmd.cmp) begin
      hit_r      <= |match;
      hit_slot_r <= match_slot;
    end
  end

  // slot payload writes
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_key) begin
        key_first_r[wr_slot]  <= pos_i_r;
        key_second_r[wr_slot] <= pos_k_r;
      end
      if (wr_cnt) cnt_r[wr_slot] <= wr_cnt_val;
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
    end
  end

  // control state: active bits, active count, free stack, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      ac_r        <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        stk_r[n] <= SLOT_W'(n);
      end
    end else begin
      if (cmd.commit) begin
        act_r <= act_nxt;
        ac_r  <= ac_nxt;
        if (push) stk_r[ac_dec[SLOT_W-1:0]] <= hit_slot_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_slot   = OUT_SLOT_W'(slot_r);

`ifndef SYNTHESIS
  // active count never passes the table size
  a_ac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ac_r <= AC_W'(TABLE_SIZE))
    else $error("active count beyond table size");

  // active bits agree with the active count
  a_ac_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(act_r) == int'(ac_r))
    else $error("active bits disagree with active count");

  // a newly granted slot comes off the free stack inactive
  a_grant_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && status_nxt == ST_GRANTED) |-> !act_r[top_slot])
    else $error("granted slot already active");

  // at most one active slot holds a given key
  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key held by more than one slot");
`endif

endmodule

[rtl/keyed_lock_table.sv]
// top level of the keyed lock table
//
// Lock manager keyed by a pair of 16-bit positions, with 16 slots.
// Input channel (in_valid/in_ready): in_mode 0 requests a lock, 1 releases
// it; in_pos_i and in_pos_k form the key.
// Result channel (out_valid/out_ready): one result per input transfer,
// out_status (granted, must wait, freed, wake one, not found, table full,
// waiter overflow) and out_slot, the slot that holds the key or 0.
// An input transfer is captured, the parallel key compare over all slots
// is registered, then the count update goes into the result register.
// The next item is not taken until the current one's compare and count
// read-modify-write are done; a new transfer is taken in the same cycle a
// result is committed, and a commit waits until the result register frees.
// Reset empties the table: no active slots, free slots handed out in order
// 0, 1, 2, and so on.
// When the receiver stalls, one result waits in the output register while
// the next item is compared; that item then holds until the register frees.
module keyed_lock_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [klt_pkg::POS_W-1:0]      in_pos_i,
  input  logic [klt_pkg::POS_W-1:0]      in_pos_k,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [klt_pkg::STATUS_W-1:0]   out_status,
  output logic [klt_pkg::OUT_SLOT_W-1:0] out_slot
);
  import klt_pkg::*;

  klt_cmd_t cmd;
  klt_sts_t sts;

  // sequencing
  klt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result register
  klt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (in_mode),
    .in_pos_i   (in_pos_i),
    .in_pos_k   (in_pos_k),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

endmodule
